// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lic_pkg.sv =====
package lic_pkg;

  localparam int CoordBits = 16;
  localparam int FracBits  = 12;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int NumW      = ProdW + 1;
  localparam int SumW      = DiffW + NumW + 1;
  localparam int DvdW      = SumW + FracBits;
  localparam int SatW      = (DvdW > 65) ? DvdW : 65;

  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_POINT      = 2'd1,
    REL_COINCIDENT = 2'd2
  } rel_e;

  typedef struct packed {
    logic signed [15:0] first_start_x;
    logic signed [15:0] first_start_y;
    logic signed [15:0] first_end_x;
    logic signed [15:0] first_end_y;
    logic signed [15:0] second_start_x;
    logic signed [15:0] second_start_y;
    logic signed [15:0] second_end_x;
    logic signed [15:0] second_end_y;
  } in_t;

  typedef struct packed {
    rel_e               relation;
    logic signed [63:0] cross_x;
    logic signed [63:0] cross_y;
  } out_t;

  typedef struct packed {
    rel_e              relation;
    logic              neg_x;
    logic              neg_y;
    logic [NumW-1:0]   divisor;
    logic [NumW-1:0]   rem_x;
    logic [NumW-1:0]   rem_y;
    logic [DvdW-1:0]   work_x;
    logic [DvdW-1:0]   work_y;
  } div_t;

  function automatic logic signed [63:0] saturate(logic [DvdW-1:0] q, logic neg);
    logic [SatW-1:0] qe;
    logic [63:0]     r;
    qe = SatW'(q);
    if (neg) begin
      if (qe > SatW'(64'h8000_0000_0000_0000)) begin
        r = 64'h8000_0000_0000_0000;
      end else begin
        r = 64'd0 - qe[63:0];
      end
    end else begin
      if (qe > SatW'(64'h7FFF_FFFF_FFFF_FFFF)) begin
        r = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        r = qe[63:0];
      end
    end
    return $signed(r);
  endfunction

endpackage

// ===== rtl/lic_front.sv =====
module lic_front
  import lic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  in_t  data_i,
  output logic valid_o,
  output div_t data_o
);

  logic a_valid_q, b_valid_q, c_valid_q, d_valid_q, e_valid_q;

  logic signed [CoordBits-1:0] a_px_q, a_py_q;
  logic signed [DiffW-1:0]     a_d1x_q, a_d1y_q, a_d2x_q, a_d2y_q, a_wx_q, a_wy_q;

  logic signed [ProdW-1:0]     b_p1_q, b_p2_q, b_p3_q, b_p4_q, b_p5_q, b_p6_q;
  logic                        b_degen_q;
  logic signed [CoordBits-1:0] b_px_q, b_py_q;
  logic signed [DiffW-1:0]     b_d1x_q, b_d1y_q;

  logic signed [NumW-1:0]      c_den_q, c_num_q;
  rel_e                        c_rel_q;
  logic signed [CoordBits-1:0] c_px_q, c_py_q;
  logic signed [DiffW-1:0]     c_d1x_q, c_d1y_q;

  logic signed [SumW-1:0]      d_bx_q, d_dx_q, d_by_q, d_dy_q;
  logic signed [NumW-1:0]      d_den_q;
  rel_e                        d_rel_q;

  div_t                        e_q;

  logic signed [CoordBits-1:0] px, py, p1x, p1y, qx, qy, q1x, q1y;
  logic signed [NumW-1:0]      den_c, num_c, col_c;
  rel_e                        rel_c;
  logic signed [SumW-1:0]      sx, sy;
  logic [SumW-1:0]             mx, my;
  div_t                        e_d;

  assign px  = $signed(data_i.first_start_x[CoordBits-1:0]);
  assign py  = $signed(data_i.first_start_y[CoordBits-1:0]);
  assign p1x = $signed(data_i.first_end_x[CoordBits-1:0]);
  assign p1y = $signed(data_i.first_end_y[CoordBits-1:0]);
  assign qx  = $signed(data_i.second_start_x[CoordBits-1:0]);
  assign qy  = $signed(data_i.second_start_y[CoordBits-1:0]);
  assign q1x = $signed(data_i.second_end_x[CoordBits-1:0]);
  assign q1y = $signed(data_i.second_end_y[CoordBits-1:0]);

  always_comb begin
    den_c = NumW'(b_p1_q) - NumW'(b_p2_q);
    num_c = NumW'(b_p3_q) - NumW'(b_p4_q);
    col_c = NumW'(b_p5_q) - NumW'(b_p6_q);
    if (b_degen_q) begin
      rel_c = REL_DISJOINT;
    end else if (den_c != '0) begin
      rel_c = REL_POINT;
    end else if (col_c == '0) begin
      rel_c = REL_COINCIDENT;
    end else begin
      rel_c = REL_DISJOINT;
    end
  end

  always_comb begin
    sx = d_bx_q + d_dx_q;
    sy = d_by_q + d_dy_q;
    mx = sx[SumW-1] ? SumW'(-sx) : SumW'(sx);
    my = sy[SumW-1] ? SumW'(-sy) : SumW'(sy);
    e_d.relation = d_rel_q;
    e_d.neg_x    = sx[SumW-1] ^ d_den_q[NumW-1];
    e_d.neg_y    = sy[SumW-1] ^ d_den_q[NumW-1];
    e_d.divisor  = d_den_q[NumW-1] ? NumW'(-d_den_q) : NumW'(d_den_q);
    e_d.rem_x    = '0;
    e_d.rem_y    = '0;
    e_d.work_x   = DvdW'(mx) << FracBits;
    e_d.work_y   = DvdW'(my) << FracBits;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_px_q  <= px;
      a_py_q  <= py;
      a_d1x_q <= DiffW'(p1x) - DiffW'(px);
      a_d1y_q <= DiffW'(p1y) - DiffW'(py);
      a_d2x_q <= DiffW'(q1x) - DiffW'(qx);
      a_d2y_q <= DiffW'(q1y) - DiffW'(qy);
      a_wx_q  <= DiffW'(qx) - DiffW'(px);
      a_wy_q  <= DiffW'(qy) - DiffW'(py);

      b_p1_q    <= a_d1x_q * a_d2y_q;
      b_p2_q    <= a_d1y_q * a_d2x_q;
      b_p3_q    <= a_wx_q * a_d2y_q;
      b_p4_q    <= a_wy_q * a_d2x_q;
      b_p5_q    <= a_wx_q * a_d1y_q;
      b_p6_q    <= a_wy_q * a_d1x_q;
      b_degen_q <= ((a_d1x_q == '0) && (a_d1y_q == '0)) ||
                   ((a_d2x_q == '0) && (a_d2y_q == '0));
      b_px_q    <= a_px_q;
      b_py_q    <= a_py_q;
      b_d1x_q   <= a_d1x_q;
      b_d1y_q   <= a_d1y_q;

      c_den_q <= den_c;
      c_num_q <= num_c;
      c_rel_q <= rel_c;
      c_px_q  <= b_px_q;
      c_py_q  <= b_py_q;
      c_d1x_q <= b_d1x_q;
      c_d1y_q <= b_d1y_q;

      d_bx_q  <= c_px_q * c_den_q;
      d_dx_q  <= c_d1x_q * c_num_q;
      d_by_q  <= c_py_q * c_den_q;
      d_dy_q  <= c_d1y_q * c_num_q;
      d_den_q <= c_den_q;
      d_rel_q <= c_rel_q;

      e_q <= e_d;
    end
  end

  assign valid_o = e_valid_q;
  assign data_o  = e_q;

endmodule

// ===== rtl/lic_div_cell.sv =====
module lic_div_cell
  import lic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic        valid_q;
  div_t        data_q, data_d;
  logic [NumW:0] tx, ty, dv, sx, sy;
  logic        gx, gy;

  always_comb begin
    dv = {1'b0, data_i.divisor};
    tx = {data_i.rem_x, data_i.work_x[DvdW-1]};
    ty = {data_i.rem_y, data_i.work_y[DvdW-1]};
    sx = tx - dv;
    sy = ty - dv;
    gx = (tx >= dv);
    gy = (ty >= dv);
    data_d        = data_i;
    data_d.rem_x  = gx ? sx[NumW-1:0] : tx[NumW-1:0];
    data_d.rem_y  = gy ? sy[NumW-1:0] : ty[NumW-1:0];
    data_d.work_x = {data_i.work_x[DvdW-2:0], gx};
    data_d.work_y = {data_i.work_y[DvdW-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/line_intersection_classifier_unit.sv =====
// Classifies two lines, each given by two 16-bit integer points, as disjoint parallel,
// coincident or meeting in one point, and gives that point in signed fixed point
// with 12 fraction bits, truncated toward zero; a line whose two points are equal
// is reported disjoint. One line pair is accepted every cycle while in_ready_o is
// high; the pipeline has five arithmetic stages and one divider cell per quotient
// bit. A skid register decouples in_ready_o from out_ready_i.
`include "assert_macros.svh"

module line_intersection_classifier_unit
  import lic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic             en;
  logic [DvdW:0]    cv;
  div_t             cd [DvdW+1];
  logic             out_valid_q, skid_valid_q;
  out_t             out_q, skid_q, fin;
  logic             take, push;

  assign en = !skid_valid_q;

  lic_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (cv[0]),
    .data_o  (cd[0])
  );

  for (genvar i = 0; i < DvdW; i++) begin : g_cell
    lic_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .data_o  (cd[i+1])
    );
  end

  always_comb begin
    fin.relation = cd[DvdW].relation;
    if (cd[DvdW].relation == REL_POINT) begin
      fin.cross_x = saturate(cd[DvdW].work_x, cd[DvdW].neg_x);
      fin.cross_y = saturate(cd[DvdW].work_y, cd[DvdW].neg_y);
    end else begin
      fin.cross_x = '0;
      fin.cross_y = '0;
    end
  end

  assign take = out_valid_q && out_ready_i;
  assign push = en && cv[DvdW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : fin;
    end else if (push) begin
      skid_q <= fin;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLY(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `ASSERT_IMPLY(a_zero_unless_point,
    out_valid_q && (out_q.relation != REL_POINT),
    (out_q.cross_x == '0) && (out_q.cross_y == '0), "nonzero point without intersection")
  `ASSERT_NEXT(a_stall_holds_tail, !en && cv[DvdW], cv[DvdW], "item dropped during stall")

endmodule
